// ===== rtl/core/sswp_pkg.sv =====
`timescale 1ns / 1ps

package sswp_pkg;

	// Field widths of the read records and results.
	localparam int unsigned FLAGS_W   = 12;
	localparam int unsigned MAPQ_W    = 8;
	localparam int unsigned TARGET_W  = 16;
	localparam int unsigned POS_W     = 31;
	localparam int unsigned HEIGHT_W  = 9;

	// Configuration port.
	localparam int unsigned REG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 9;
	localparam logic [REG_IDX_W-1:0] REG_MIN_MAPQ = 4'd0;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW   = 4'd1;

	// Register reset values.
	localparam logic [MAPQ_W-1:0]     MIN_MAPQ_RESET = 8'd1;
	localparam logic [CFG_DATA_W-1:0] WINDOW_RESET   = 9'd250;

	// Flag bits: unmapped, secondary, QC fail, duplicate and supplementary drop a read.
	localparam logic [FLAGS_W-1:0] FILTER_MASK = 12'hF04;
	localparam int unsigned FLAG_REVERSE_BIT = 4;
	localparam int unsigned FLAG_FIRST_BIT   = 6;

	// One input record.
	typedef struct packed {
		logic                       new_contig;
		logic [FLAGS_W-1:0]         flags;
		logic [MAPQ_W-1:0]          map_quality;
		logic signed [TARGET_W-1:0] target_index;
		logic [POS_W-1:0]           position;
	} item_t;

	// One result.
	typedef struct packed {
		logic [HEIGHT_W-1:0] switch_height;
		logic [POS_W-1:0]    middle_position;
	} result_t;

	// Classified operation handed from the front end to the back end.
	typedef struct packed {
		logic             clear;
		logic             keep;
		logic             emit_ok;
		logic             strand;
		logic [POS_W-1:0] position;
	} op_t;

endpackage

// ===== rtl/core/strand_switch_window_profile.sv =====
`timescale 1ns / 1ps

// Strand-switch window profile. Read records are pushed in position order, one per
// cycle while full is low; filtered reads are taken but move no window. A kept read
// updates a ring of the last W positions and two W-read strand windows, and once 2W
// reads are seen it yields the height |older count - newer count| at the middle
// position, suppressed when that position repeats. The front end filters and assigns
// the ring slot in the push cycle; the back end does the ring read-modify-write in
// one stage (registered read, write-back forwarded). The rate is set by the single
// ring memory port pair: one read per cycle sustained while the result queue has
// room. Writing the window register or pushing a read with new_contig clears all
// window state. Configuration writes are taken every cycle and must only be issued
// while the block is idle.
module strand_switch_window_profile #(
	parameter int unsigned MAX_WINDOW = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sswp_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [sswp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            push,
	output logic                            full,
	input  sswp_pkg::item_t                 item,
	output logic                            empty,
	input  logic                            pop,
	output sswp_pkg::result_t               result
);

	import sswp_pkg::*;

	localparam int unsigned IDX_W  = $clog2(MAX_WINDOW);
	localparam int unsigned OPQ_W  = $bits(op_t) + IDX_W;

	logic             cfg_clear;
	logic             accept;
	logic             op_push;
	op_t              op_in;
	logic [IDX_W-1:0] p_in;
	logic             op_full;
	logic             op_empty;
	logic             op_pop;
	logic [OPQ_W-1:0] op_head;
	op_t              op_out;
	logic [IDX_W-1:0] p_out;
	logic             res_push;
	result_t          res;
	logic             res_full;

	assign cfg_ready = 1'b1;
	assign full      = op_full;
	assign accept    = push && !op_full;

	// Front end: filter, strand bit and ring slot.
	sswp_front #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_clear (cfg_clear),
		.item      (item),
		.accept    (accept),
		.op_push   (op_push),
		.op        (op_in),
		.op_p      (p_in)
	);

	// Operation queue between the two halves.
	sswp_fifo #(
		.WIDTH(OPQ_W),
		.DEPTH(4)
	) u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op_push),
		.wdata  ({op_in, p_in}),
		.full   (op_full),
		.pop    (op_pop),
		.rdata  (op_head),
		.empty  (op_empty)
	);

	assign op_out = op_head[OPQ_W-1:IDX_W];
	assign p_out  = op_head[IDX_W-1:0];

	// Back end: ring update, window counts and result.
	sswp_back #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_clear (cfg_clear),
		.op_valid  (!op_empty),
		.op        (op_out),
		.op_p      (p_out),
		.op_pop    (op_pop),
		.res_push  (res_push),
		.res       (res),
		.res_full  (res_full)
	);

	// Result queue toward the consumer.
	sswp_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(2)
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

// ===== rtl/core/sswp_fifo.sv =====
`timescale 1ns / 1ps

module sswp_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = store_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/sswp_front.sv =====
`timescale 1ns / 1ps

module sswp_front #(
	parameter int unsigned MAX_WINDOW = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [sswp_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [sswp_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              cfg_clear,
	input  sswp_pkg::item_t                   item,
	input  logic                              accept,
	output logic                              op_push,
	output sswp_pkg::op_t                     op,
	output logic [$clog2(MAX_WINDOW)-1:0]     op_p
);

	import sswp_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_WINDOW);
	localparam int unsigned WIN_W = $clog2(MAX_WINDOW + 1);
	localparam int unsigned RS_W  = $clog2(2 * MAX_WINDOW + 1);
	localparam int unsigned W_RESET =
		(int'(WINDOW_RESET) > MAX_WINDOW) ? MAX_WINDOW : int'(WINDOW_RESET);

	logic [MAPQ_W-1:0] min_mapq_q;
	logic [WIN_W-1:0]  window_q;
	logic [IDX_W-1:0]  ring_q;
	logic [RS_W-1:0]   seen_q;

	logic              keep;
	logic [IDX_W-1:0]  ring_base;
	logic [RS_W-1:0]   seen_base;
	logic [RS_W-1:0]   seen_next;
	logic [RS_W-1:0]   two_w;
	logic [IDX_W-1:0]  p;
	logic [WIN_W-1:0]  p_inc;
	logic [IDX_W-1:0]  ring_next;
	logic [WIN_W-1:0]  window_eff;

	// A write of the window length clears all window state.
	assign cfg_clear = cfg_valid && (cfg_index == REG_WINDOW);

	// Window length clamped to 1..MAX_WINDOW at write time.
	always_comb begin
		if (cfg_data == '0) begin
			window_eff = WIN_W'(1);
		end else if (32'(cfg_data) > 32'(MAX_WINDOW)) begin
			window_eff = WIN_W'(MAX_WINDOW);
		end else begin
			window_eff = WIN_W'(cfg_data);
		end
	end

	// Record filter.
	assign keep = ((item.flags & FILTER_MASK) == '0)
		&& (item.map_quality >= min_mapq_q)
		&& !item.target_index[TARGET_W-1];

	// Ring slot and read count, with a new contig clearing them first.
	always_comb begin
		ring_base = item.new_contig ? '0 : ring_q;
		seen_base = item.new_contig ? '0 : seen_q;
		two_w     = RS_W'(window_q) << 1;
		p         = (WIN_W'(ring_base) >= window_q) ? '0 : ring_base;
		p_inc     = WIN_W'(p) + 1'b1;
		ring_next = (p_inc >= window_q) ? '0 : p_inc[IDX_W-1:0];
		seen_next = (seen_base < two_w) ? seen_base + 1'b1 : seen_base;
	end

	assign op_push     = accept && (keep || item.new_contig);
	assign op.clear    = item.new_contig;
	assign op.keep     = keep;
	assign op.emit_ok  = (seen_next >= two_w);
	assign op.strand   = item.flags[FLAG_FIRST_BIT] ^ ~item.flags[FLAG_REVERSE_BIT];
	assign op.position = item.position;
	assign op_p        = p;

	// Configuration registers and front-end window state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_mapq_q <= MIN_MAPQ_RESET;
			window_q   <= WIN_W'(W_RESET);
			ring_q     <= '0;
			seen_q     <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_MIN_MAPQ: begin
						min_mapq_q <= cfg_data[MAPQ_W-1:0];
					end
					REG_WINDOW: begin
						window_q <= window_eff;
						ring_q   <= '0;
						seen_q   <= '0;
					end
					default: begin
					end
				endcase
			end else if (accept) begin
				if (keep) begin
					ring_q <= ring_next;
					seen_q <= seen_next;
				end else if (item.new_contig) begin
					ring_q <= '0;
					seen_q <= '0;
				end
			end
		end
	end

endmodule

// ===== rtl/core/sswp_back.sv =====
`timescale 1ns / 1ps

module sswp_back #(
	parameter int unsigned MAX_WINDOW = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_clear,
	input  logic                          op_valid,
	input  sswp_pkg::op_t                 op,
	input  logic [$clog2(MAX_WINDOW)-1:0] op_p,
	output logic                          op_pop,
	output logic                          res_push,
	output sswp_pkg::result_t             res,
	input  logic                          res_full
);

	import sswp_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_WINDOW);
	localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int unsigned ENT_W = POS_W + 2;

	// Ring entry: position, newer strand bit, older strand bit.
	logic [ENT_W-1:0]      ring_mem [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] valid_q;
	logic [CNT_W-1:0]      newer_q;
	logic [CNT_W-1:0]      older_q;
	logic [POS_W-1:0]      last_q;

	logic                  s1_valid_q;
	op_t                   op_s1;
	logic [IDX_W-1:0]      p_s1;
	logic [ENT_W-1:0]      rd_s1;
	logic                  fwd_hit_s1;
	logic [ENT_W-1:0]      fwd_data_s1;

	logic                  s1_ready;
	logic                  s1_fire;
	logic                  load;
	logic                  entry_ok;
	logic [ENT_W-1:0]      entry;
	logic [POS_W-1:0]      mid;
	logic                  old_newer;
	logic                  old_older;
	logic [CNT_W-1:0]      newer_base;
	logic [CNT_W-1:0]      older_base;
	logic [CNT_W-1:0]      newer_next;
	logic [CNT_W-1:0]      older_next;
	logic [POS_W-1:0]      last_base;
	logic [CNT_W-1:0]      diff;
	logic [CNT_W+HEIGHT_W-1:0] diff_ext;
	logic                  emit;
	logic                  wr_en;
	logic [ENT_W-1:0]      wr_data;
	logic [MAX_WINDOW-1:0] valid_base;

	// Stage handshake.
	assign s1_fire  = s1_valid_q && !res_full;
	assign s1_ready = !s1_valid_q || s1_fire;
	assign load     = op_valid && s1_ready;
	assign op_pop   = load;

	// Old entry: cleared state reads as zero; a write at the read edge is forwarded.
	always_comb begin
		entry_ok   = valid_q[p_s1] && !op_s1.clear;
		entry      = fwd_hit_s1 ? fwd_data_s1 : rd_s1;
		mid        = entry_ok ? entry[ENT_W-1:2] : '0;
		old_newer  = entry_ok && entry[1];
		old_older  = entry_ok && entry[0];
		newer_base = op_s1.clear ? '0 : newer_q;
		older_base = op_s1.clear ? '0 : older_q;
		last_base  = op_s1.clear ? '0 : last_q;
		valid_base = op_s1.clear ? '0 : valid_q;
		older_next = older_base + CNT_W'(old_newer) - CNT_W'(old_older);
		newer_next = newer_base + CNT_W'(op_s1.strand) - CNT_W'(old_newer);
		diff       = (older_next >= newer_next) ? older_next - newer_next
		                                        : newer_next - older_next;
		diff_ext   = (CNT_W + HEIGHT_W)'(diff);
		emit       = op_s1.keep && op_s1.emit_ok && (mid != last_base);
	end

	assign wr_en   = s1_fire && op_s1.keep;
	assign wr_data = {op_s1.position, op_s1.strand, old_newer};

	assign res_push            = s1_fire && emit;
	assign res.switch_height   = diff_ext[HEIGHT_W-1:0];
	assign res.middle_position = mid;

	// Ring memory with registered read, and the stage payload.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[p_s1] <= wr_data;
		end
		if (load) begin
			rd_s1       <= ring_mem[op_p];
			fwd_data_s1 <= wr_data;
			op_s1       <= op;
			p_s1        <= op_p;
		end
	end

	// Stage control and window counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			fwd_hit_s1 <= 1'b0;
			valid_q    <= '0;
			newer_q    <= '0;
			older_q    <= '0;
			last_q     <= '0;
		end else begin
			if (s1_ready) begin
				s1_valid_q <= op_valid;
			end
			if (load) begin
				fwd_hit_s1 <= wr_en && (p_s1 == op_p);
			end
			if (cfg_clear) begin
				valid_q <= '0;
				newer_q <= '0;
				older_q <= '0;
				last_q  <= '0;
			end else if (s1_fire) begin
				if (op_s1.keep) begin
					valid_q <= valid_base | (MAX_WINDOW'(1) << p_s1);
					newer_q <= newer_next;
					older_q <= older_next;
					last_q  <= emit ? mid : last_base;
				end else if (op_s1.clear) begin
					valid_q <= '0;
					newer_q <= '0;
					older_q <= '0;
					last_q  <= '0;
				end
			end
		end
	end

endmodule

// ===== rtl/core/sswp_checker.sv =====
`timescale 1ns / 1ps

module sswp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              push,
	input logic              full,
	input logic              empty,
	input logic              pop,
	input sswp_pkg::result_t result
);

	// While reset is held both queues report idle.
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> (empty && !full))
		else $error("queues not idle during reset");

	// A waiting result carries no unknown bits.
	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !$isunknown(result))
		else $error("waiting result has unknown bits");

	// The input side only fills up through an accepted transaction.
	a_full_by_push: assert property (@(posedge clk) disable iff (!arst_n)
		(!full && !push) |=> !full)
		else $error("full rose without an input transaction");

	// A waiting result holds until it is taken.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed before its transaction");

endmodule

bind strand_switch_window_profile sswp_checker u_checker (.*);
